/* hw/rtl/jsu_pkg.sv */
// jsu_pkg: shared types and codes for the JSON string unescape block.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_top.
package jsu_pkg;

  localparam int CP_W        = 21;
  localparam int HALF_W      = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_CTRL       = 3'd1;
  localparam logic [2:0] ERR_EOT        = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd4;
  localparam logic [2:0] ERR_UNTERM_HEX = 3'd5;
  localparam logic [2:0] ERR_MISS_HALF  = 3'd6;
  localparam logic [2:0] ERR_LONE_LOW   = 3'd7;

  // One decoded record: one result, or two when a pair is emitted split.
  typedef struct packed {
    logic              two;
    logic [CP_W-1:0]   ch0;
    logic [HALF_W-1:0] ch1;
    logic [1:0]        kind;
    logic [2:0]        err;
  } rec_t;

endpackage

/* hw/rtl/jsu_front.sv */
// jsu_front: escape decoder state machine, one code point per cycle while accept is high.
// Depends on jsu_pkg; produces rec_t records for jsu_queue.
module jsu_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     accept,
  input  logic [jsu_pkg::CP_W-1:0] code_point,
  output logic                     rec_valid,
  output jsu_pkg::rec_t            rec
);
  import jsu_pkg::*;

  localparam logic [3:0] PH_NORMAL = 4'd0;
  localparam logic [3:0] PH_ESC    = 4'd1;
  localparam logic [3:0] PH_HEX0   = 4'd2;
  localparam logic [3:0] PH_HEX1   = 4'd3;
  localparam logic [3:0] PH_HEX2   = 4'd4;
  localparam logic [3:0] PH_HEX3   = 4'd5;
  localparam logic [3:0] PH_BSL    = 4'd6;
  localparam logic [3:0] PH_UCH    = 4'd7;
  localparam logic [3:0] PH_LOW0   = 4'd8;
  localparam logic [3:0] PH_LOW1   = 4'd9;
  localparam logic [3:0] PH_LOW2   = 4'd10;
  localparam logic [3:0] PH_LOW3   = 4'd11;

  localparam logic [CP_W-1:0] C_BSL   = CP_W'(8'h5C);
  localparam logic [CP_W-1:0] C_QUOTE = CP_W'(8'h22);
  localparam logic [CP_W-1:0] C_SLASH = CP_W'(8'h2F);
  localparam logic [CP_W-1:0] C_SPACE = CP_W'(8'h20);
  localparam logic [CP_W-1:0] C_LC_B  = CP_W'(8'h62);
  localparam logic [CP_W-1:0] C_LC_F  = CP_W'(8'h66);
  localparam logic [CP_W-1:0] C_LC_N  = CP_W'(8'h6E);
  localparam logic [CP_W-1:0] C_LC_R  = CP_W'(8'h72);
  localparam logic [CP_W-1:0] C_LC_T  = CP_W'(8'h74);
  localparam logic [CP_W-1:0] C_LC_U  = CP_W'(8'h75);

  localparam logic [HALF_W-1:0] HI_MIN = 16'hD800;
  localparam logic [HALF_W-1:0] HI_MAX = 16'hDBFF;
  localparam logic [HALF_W-1:0] LO_MIN = 16'hDC00;
  localparam logic [HALF_W-1:0] LO_MAX = 16'hDFFF;

  // Bit 4 set: not a hex digit.
  function automatic logic [4:0] hex_val(input logic [CP_W-1:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= CP_W'(8'h30) && c <= CP_W'(8'h39)) r = {1'b0, 4'(c - CP_W'(8'h30))};
    else if (c >= CP_W'(8'h61) && c <= CP_W'(8'h66)) r = {1'b0, 4'(c - CP_W'(8'h57))};
    else if (c >= CP_W'(8'h41) && c <= CP_W'(8'h46)) r = {1'b0, 4'(c - CP_W'(8'h37))};
    return r;
  endfunction

  logic              merge_r;
  logic [3:0]        phase_r, phase_nxt;
  logic [HALF_W-1:0] acc_r, acc_nxt;
  logic [HALF_W-1:0] hi_r, hi_nxt;
  logic [4:0]        hv;
  logic [HALF_W-1:0] acc_sh;
  logic              restart;

  assign hv     = hex_val(code_point);
  assign acc_sh = {acc_r[HALF_W-5:0], hv[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    hi_nxt    = hi_r;
    restart   = 1'b0;
    rec_valid = 1'b0;
    rec       = '0;
    rec.kind  = KIND_CHAR;
    rec.err   = ERR_NONE;
    if (code_point == '0) begin
      restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_EOT;
    end else if (code_point < C_SPACE) begin
      restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_CTRL;
    end else begin
      unique case (phase_r) inside
        PH_NORMAL: begin
          if (code_point == C_BSL) begin
            phase_nxt = PH_ESC;
          end else if (code_point == C_QUOTE) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_CLOSE;
          end else begin
            rec_valid = 1'b1; rec.ch0 = code_point;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_NORMAL;
          rec_valid = 1'b1;
          if (code_point == C_BSL || code_point == C_QUOTE || code_point == C_SLASH) begin
            rec.ch0 = code_point;
          end else if (code_point == C_LC_B) begin
            rec.ch0 = CP_W'(8'h08);
          end else if (code_point == C_LC_F) begin
            rec.ch0 = CP_W'(8'h0C);
          end else if (code_point == C_LC_N) begin
            rec.ch0 = CP_W'(8'h0A);
          end else if (code_point == C_LC_R) begin
            rec.ch0 = CP_W'(8'h0D);
          end else if (code_point == C_LC_T) begin
            rec.ch0 = CP_W'(8'h09);
          end else if (code_point == C_LC_U) begin
            rec_valid = 1'b0; phase_nxt = PH_HEX0; acc_nxt = '0;
          end else begin
            restart = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_BAD_ESC;
          end
        end
        PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
          if (code_point == C_QUOTE) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR;
            rec.err = ERR_UNTERM_HEX;
          end else if (hv[4]) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_BAD_HEX;
          end else if (phase_r != PH_HEX3) begin
            acc_nxt = acc_sh; phase_nxt = phase_r + 4'd1;
          end else if (acc_sh >= HI_MIN && acc_sh <= HI_MAX) begin
            hi_nxt = acc_sh; acc_nxt = '0; phase_nxt = PH_BSL;
          end else if (acc_sh >= LO_MIN && acc_sh <= LO_MAX) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_LONE_LOW;
          end else begin
            restart = 1'b1; rec_valid = 1'b1; rec.ch0 = CP_W'(acc_sh);
          end
        end
        PH_BSL: begin
          if (code_point != C_BSL) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_MISS_HALF;
          end else begin
            phase_nxt = PH_UCH;
          end
        end
        PH_UCH: begin
          if (code_point != C_LC_U) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_MISS_HALF;
          end else begin
            phase_nxt = PH_LOW0; acc_nxt = '0;
          end
        end
        PH_LOW0, PH_LOW1, PH_LOW2, PH_LOW3: begin
          if (code_point == C_QUOTE) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_MISS_HALF;
          end else if (hv[4]) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_BAD_HEX;
          end else if (phase_r != PH_LOW3) begin
            acc_nxt = acc_sh; phase_nxt = phase_r + 4'd1;
          end else if (acc_sh < LO_MIN || acc_sh > LO_MAX) begin
            restart = 1'b1; rec_valid = 1'b1; rec.kind = KIND_ERR; rec.err = ERR_MISS_HALF;
          end else begin
            restart   = 1'b1;
            rec_valid = 1'b1;
            if (merge_r) begin
              // 0x10000 + high ten bits : low ten bits
              rec.ch0 = {1'b0, hi_r[9:0], acc_sh[9:0]} + CP_W'(32'h10000);
            end else begin
              rec.two = 1'b1;
              rec.ch0 = CP_W'(hi_r);
              rec.ch1 = acc_sh;
            end
          end
        end
        default: begin
          restart = 1'b1; rec_valid = 1'b1; rec.ch0 = code_point;
        end
      endcase
    end
    if (restart) begin
      phase_nxt = PH_NORMAL;
      acc_nxt   = '0;
      hi_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r <= 1'b1;
      phase_r <= PH_NORMAL;
      acc_r   <= '0;
      hi_r    <= '0;
    end else begin
      if (cfg_we) merge_r <= cfg_wdata;
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        hi_r    <= hi_nxt;
      end
    end
  end

endmodule

/* hw/rtl/jsu_queue.sv */
// jsu_queue: small register queue of decoded records between front and back.
// Depends on jsu_pkg for rec_t.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::rec_t push_rec,
  input  logic          pop,
  output jsu_pkg::rec_t head,
  output logic          empty,
  output logic          full
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wrap_inc(wr_r);
      if (pop)  rd_r <= wrap_inc(rd_r);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (!push && pop) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

/* hw/rtl/jsu_back.sv */
// jsu_back: expands queued records into results and holds the output register.
// Depends on jsu_pkg; reads the head of jsu_queue.
module jsu_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  jsu_pkg::rec_t            head,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic                     out_pop,
  output logic                     out_empty,
  output logic [jsu_pkg::CP_W-1:0] out_char_out,
  output logic [1:0]               out_kind,
  output logic [2:0]               out_error_code,
  output logic                     out_last
);
  import jsu_pkg::*;

  logic            valid_r;
  logic            idx_r, idx_nxt;
  logic            load;
  logic [CP_W-1:0] ch_r, ch_nxt;
  logic [1:0]      kind_r;
  logic [2:0]      err_r;
  logic            last_r, last_nxt;

  assign load = !q_empty && (!valid_r || out_pop);

  always_comb begin
    idx_nxt  = idx_r;
    q_pop    = 1'b0;
    ch_nxt   = head.ch0;
    last_nxt = 1'b1;
    if (load) begin
      if (idx_r) begin
        ch_nxt  = CP_W'(head.ch1);
        idx_nxt = 1'b0;
        q_pop   = 1'b1;
      end else if (head.two) begin
        last_nxt = 1'b0;
        idx_nxt  = 1'b1;
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load)         valid_r <= 1'b1;
      else if (out_pop) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r   <= ch_nxt;
      kind_r <= head.kind;
      err_r  <= head.err;
      last_r <= last_nxt;
    end
  end

  assign out_empty      = !valid_r;
  assign out_char_out   = ch_r;
  assign out_kind       = kind_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

endmodule

/* hw/rtl/json_string_unescape_top.sv */
// json_string_unescape_top: streaming decoder for the body of a JSON string.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Usage:
//   Input is a queue write port: present one code point on in_code_point and
//   raise in_push; the transfer happens at a clock edge where in_full is low.
//   Results are a queue read port: while out_empty is low the oldest result
//   sits on out_char_out / out_kind / out_error_code / out_last; raise
//   out_pop to transfer it.
//   cfg_we/cfg_wdata write merge_surrogates (reset 1); write it only idle.
// Timing:
//   One code point per cycle while in_full is low. A result is registered
//   first in the record queue at its input transfer edge, then in the output
//   register. A split surrogate pair gives two results; the record queue
//   between decoder and output stage absorbs that.
// Stall:
//   When out_pop stays low the output register holds, the record queue fills
//   up to QUEUE_DEPTH records and then in_full rises until results drain.
// Reset:
//   rst_n low (synchronous) empties the queue and output, returns the decoder
//   to the normal character phase and sets merge_surrogates to 1.
module json_string_unescape_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [jsu_pkg::CP_W-1:0] in_code_point,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [jsu_pkg::CP_W-1:0] out_char_out,
  output logic [1:0]               out_kind,
  output logic [2:0]               out_error_code,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata
);
  import jsu_pkg::*;

  logic accept;
  logic rec_valid;
  rec_t rec;
  rec_t head;
  logic q_empty;
  logic q_pop;

  // Take an item only when the record queue has room for its result.
  assign accept = in_push && !in_full;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .code_point (in_code_point),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  // Push only items that produce results; escape prefixes and hex digits drop.
  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept && rec_valid),
    .push_rec (rec),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (in_full)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_char_out   (out_char_out),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  // Only character results carry a code point.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != KIND_CHAR) |-> out_char_out == '0)
    else $error("non-character result carries a code point");

  // An error code is present exactly on error results.
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_kind == KIND_ERR) == (out_error_code != ERR_NONE)))
    else $error("error code and kind disagree");

  // The first half of a split pair is a character and is followed by its partner.
  a_first_half: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> out_kind == KIND_CHAR)
    else $error("non-final result is not a character");

  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last && out_pop) |=> (!out_empty && out_last))
    else $error("second half of a pair did not follow");

endmodule
